// ----- rtl/c816e_pkg.sv -----
// Shared types, constants and opcode table for the 65C816 statement encoder.
// No dependencies.
package c816e_pkg;

    typedef struct packed {
        logic [6:0]  cmd;
        logic [2:0]  mode;
        logic [1:0]  modifier;
        logic signed [31:0] operand;
        logic        operand_known;
        logic        final_pass;
        logic [23:0] pc;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [2:0] byte_count;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
    } t_rsp;

    typedef enum logic [3:0] {
        K_PRI, K_RMW, K_BRA, K_IMP, K_BIT, K_LDX, K_DB, K_DW, K_JMP, K_JSL,
        K_PEA, K_PSR, K_STA, K_STY, K_STZ
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } t_entry;

    localparam logic [2:0] M_IMPL = 3'd0;
    localparam logic [2:0] M_ACC  = 3'd1;
    localparam logic [2:0] M_IMM  = 3'd2;
    localparam logic [2:0] M_ABS  = 3'd3;
    localparam logic [2:0] M_ABSX = 3'd4;
    localparam logic [2:0] M_SR   = 3'd5;
    localparam logic [2:0] M_INDX = 3'd6;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_MODE    = 3'd2;
    localparam logic [2:0] ST_LARGE   = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;
    localparam logic [2:0] ST_BANK    = 3'd5;

    localparam logic [1:0] MOD_LOW  = 2'd1;
    localparam logic [1:0] MOD_MID  = 2'd2;
    localparam logic [1:0] MOD_HIGH = 2'd3;

    localparam logic [7:0] OFS_IMM   = 8'h09;
    localparam logic [7:0] OFS_DP    = 8'h05;
    localparam logic [7:0] OFS_ABS   = 8'h0D;
    localparam logic [7:0] OFS_LONG  = 8'h0F;
    localparam logic [7:0] OFS_ABSX  = 8'h1D;
    localparam logic [7:0] OFS_LONGX = 8'h1F;
    localparam logic [7:0] OFS_DPX   = 8'h15;
    localparam logic [7:0] OFS_SR    = 8'h03;
    localparam logic [7:0] OP_STA_LONG  = 8'h8F;
    localparam logic [7:0] OP_STA_ABSX  = 8'h9D;
    localparam logic [7:0] OP_STA_LONGX = 8'h9F;

    localparam logic [6:0] CMD_LAST = 7'd76;

    localparam logic [0:0] CFG_ACC_WIDE   = 1'b0;
    localparam logic [0:0] CFG_INDEX_WIDE = 1'b1;

    function automatic t_entry optab(input logic [6:0] cmd);
        t_entry e;
        e = '{K_IMP, 8'h00, 8'h00, 8'h00};
        case (cmd)
            7'd0:  e = '{K_PRI, 8'h60, 8'h00, 8'h00};
            7'd1:  e = '{K_PRI, 8'h20, 8'h00, 8'h00};
            7'd2:  e = '{K_RMW, 8'h0A, 8'h06, 8'h0E};
            7'd3:  e = '{K_BRA, 8'h90, 8'h00, 8'h00};
            7'd4:  e = '{K_BRA, 8'hB0, 8'h00, 8'h00};
            7'd5:  e = '{K_BRA, 8'hF0, 8'h00, 8'h00};
            7'd6:  e = '{K_BIT, 8'h89, 8'h24, 8'h2C};
            7'd7:  e = '{K_BRA, 8'h30, 8'h00, 8'h00};
            7'd8:  e = '{K_BRA, 8'hD0, 8'h00, 8'h00};
            7'd9:  e = '{K_BRA, 8'h10, 8'h00, 8'h00};
            7'd10: e = '{K_BRA, 8'h80, 8'h00, 8'h00};
            7'd11: e = '{K_BRA, 8'h50, 8'h00, 8'h00};
            7'd12: e = '{K_BRA, 8'h70, 8'h00, 8'h00};
            7'd13: e = '{K_IMP, 8'h18, 8'h00, 8'h00};
            7'd14: e = '{K_IMP, 8'hD8, 8'h00, 8'h00};
            7'd15: e = '{K_IMP, 8'h58, 8'h00, 8'h00};
            7'd16: e = '{K_IMP, 8'hB8, 8'h00, 8'h00};
            7'd17: e = '{K_PRI, 8'hC0, 8'h00, 8'h00};
            7'd18: e = '{K_DB,  8'h00, 8'h00, 8'h00};
            7'd19: e = '{K_RMW, 8'h3A, 8'hC6, 8'hCE};
            7'd20: e = '{K_IMP, 8'hCA, 8'h00, 8'h00};
            7'd21: e = '{K_IMP, 8'h88, 8'h00, 8'h00};
            7'd22: e = '{K_DW,  8'h00, 8'h00, 8'h00};
            7'd23: e = '{K_PRI, 8'h40, 8'h00, 8'h00};
            7'd24: e = '{K_RMW, 8'h1A, 8'hE6, 8'hEE};
            7'd25: e = '{K_IMP, 8'hE8, 8'h00, 8'h00};
            7'd26: e = '{K_IMP, 8'hC8, 8'h00, 8'h00};
            7'd27: e = '{K_JMP, 8'h4C, 8'h00, 8'h00};
            7'd28: e = '{K_JSL, 8'h22, 8'h00, 8'h00};
            7'd29: e = '{K_JMP, 8'h20, 8'h00, 8'h00};
            7'd30: e = '{K_PRI, 8'hA0, 8'h00, 8'h00};
            7'd31: e = '{K_LDX, 8'hA2, 8'hA6, 8'hAE};
            7'd32: e = '{K_RMW, 8'h4A, 8'h46, 8'h4E};
            7'd33: e = '{K_IMP, 8'hEA, 8'h00, 8'h00};
            7'd34: e = '{K_PRI, 8'h00, 8'h00, 8'h00};
            7'd35: e = '{K_PEA, 8'hF4, 8'h00, 8'h00};
            7'd36: e = '{K_IMP, 8'h48, 8'h00, 8'h00};
            7'd37: e = '{K_IMP, 8'h8B, 8'h00, 8'h00};
            7'd38: e = '{K_IMP, 8'h0B, 8'h00, 8'h00};
            7'd39: e = '{K_IMP, 8'h4B, 8'h00, 8'h00};
            7'd40: e = '{K_IMP, 8'h08, 8'h00, 8'h00};
            7'd41: e = '{K_IMP, 8'hDA, 8'h00, 8'h00};
            7'd42: e = '{K_IMP, 8'h5A, 8'h00, 8'h00};
            7'd43: e = '{K_IMP, 8'h68, 8'h00, 8'h00};
            7'd44: e = '{K_IMP, 8'hAB, 8'h00, 8'h00};
            7'd45: e = '{K_IMP, 8'h2B, 8'h00, 8'h00};
            7'd46: e = '{K_IMP, 8'h28, 8'h00, 8'h00};
            7'd47: e = '{K_IMP, 8'hFA, 8'h00, 8'h00};
            7'd48: e = '{K_IMP, 8'h7A, 8'h00, 8'h00};
            7'd49: e = '{K_PSR, 8'hC2, 8'h00, 8'h00};
            7'd50: e = '{K_IMP, 8'h40, 8'h00, 8'h00};
            7'd51: e = '{K_IMP, 8'h6B, 8'h00, 8'h00};
            7'd52: e = '{K_IMP, 8'h60, 8'h00, 8'h00};
            7'd53: e = '{K_PRI, 8'hE0, 8'h00, 8'h00};
            7'd54: e = '{K_IMP, 8'h38, 8'h00, 8'h00};
            7'd55: e = '{K_IMP, 8'hF8, 8'h00, 8'h00};
            7'd56: e = '{K_IMP, 8'h78, 8'h00, 8'h00};
            7'd57: e = '{K_PSR, 8'hE2, 8'h00, 8'h00};
            7'd58: e = '{K_STA, 8'h81, 8'h85, 8'h8D};
            7'd59: e = '{K_IMP, 8'hDB, 8'h00, 8'h00};
            7'd60: e = '{K_STY, 8'h94, 8'h84, 8'h8C};
            7'd61: e = '{K_STZ, 8'h00, 8'h64, 8'h9C};
            7'd62: e = '{K_IMP, 8'h5B, 8'h00, 8'h00};
            7'd63: e = '{K_IMP, 8'h1B, 8'h00, 8'h00};
            7'd64: e = '{K_IMP, 8'hAA, 8'h00, 8'h00};
            7'd65: e = '{K_IMP, 8'hA8, 8'h00, 8'h00};
            7'd66: e = '{K_IMP, 8'h7B, 8'h00, 8'h00};
            7'd67: e = '{K_IMP, 8'h3B, 8'h00, 8'h00};
            7'd68: e = '{K_IMP, 8'hBA, 8'h00, 8'h00};
            7'd69: e = '{K_IMP, 8'h8A, 8'h00, 8'h00};
            7'd70: e = '{K_IMP, 8'h9A, 8'h00, 8'h00};
            7'd71: e = '{K_IMP, 8'h9B, 8'h00, 8'h00};
            7'd72: e = '{K_IMP, 8'h98, 8'h00, 8'h00};
            7'd73: e = '{K_IMP, 8'hBB, 8'h00, 8'h00};
            7'd74: e = '{K_IMP, 8'hCB, 8'h00, 8'h00};
            7'd75: e = '{K_IMP, 8'hEB, 8'h00, 8'h00};
            7'd76: e = '{K_IMP, 8'hFB, 8'h00, 8'h00};
            default: e = '{K_IMP, 8'h00, 8'h00, 8'h00};
        endcase
        return e;
    endfunction

endpackage

// ----- rtl/c816e_encode.sv -----
// Combinational encoder for one statement: table lookup, size and range checks.
// Depends on c816e_pkg.
module c816e_encode
    import c816e_pkg::*;
(
    input  t_req i_req,
    input  logic i_acc_wide,
    input  logic i_index_wide,
    output t_rsp o_rsp
);

    t_entry             e;
    logic signed [32:0] s;
    logic [31:0]        u;
    logic [2:0]         st;
    logic [2:0]         n;
    logic [7:0]         op;
    logic [31:0]        val;
    logic signed [33:0] rel;
    logic               w;
    logic               zero_bytes;
    logic [31:0]        imm_w;
    logic [31:0]        imm_n;
    logic               fits8, fits16, fits24;

    // Pick the immediate value for the current byte select
    function automatic logic [31:0] imm_sel(input logic [31:0] uu, input logic [1:0] md,
                                            input logic wd);
        logic [31:0] r;
        r = uu;
        if (wd) begin
            if (md == MOD_HIGH) r = {16'd0, uu[23:8]};
            else if (md == MOD_MID || md == MOD_LOW) r = {16'd0, uu[15:0]};
        end else begin
            if (md == MOD_HIGH) r = {24'd0, uu[23:16]};
            else if (md == MOD_MID) r = {24'd0, uu[15:8]};
            else if (md == MOD_LOW) r = {24'd0, uu[7:0]};
        end
        return r;
    endfunction

    assign u      = i_req.operand;
    assign s      = {i_req.operand[31], i_req.operand};
    assign e      = optab(i_req.cmd);
    assign fits8  = s <= 33'sd255;
    assign fits16 = s <= 33'sd65535;
    assign fits24 = s <= 33'sd16777215;
    assign imm_w  = imm_sel(u, i_req.modifier, 1'b1);
    assign imm_n  = imm_sel(u, i_req.modifier, 1'b0);
    assign rel    = {s[32], s} - {10'd0, i_req.pc} - 34'sd2;

    // Decode status, length, opcode and operand value
    always_comb begin
        st  = ST_OK;
        n   = 3'd0;
        op  = 8'h00;
        val = 32'd0;
        w   = (e.kind == K_BIT || e.kind == K_PRI) ? i_acc_wide : i_index_wide;
        zero_bytes = 1'b0;
        if (i_req.cmd > CMD_LAST) begin
            st = ST_MODE;
        end else if (e.kind != K_IMP && !i_req.operand_known) begin
            zero_bytes = 1'b1;
            if (i_req.final_pass) begin
                st = ST_UNKNOWN;
            end else begin
                case (e.kind)
                    K_PRI: begin
                        if (i_req.mode == M_IMM) n = i_acc_wide ? 3'd3 : 3'd2;
                        else if (i_req.mode == M_SR) n = 3'd2;
                        else if (i_req.mode == M_ABS || i_req.mode == M_ABSX)
                            n = 3'd4;
                        else st = ST_MODE;
                    end
                    K_BIT, K_LDX: begin
                        if (i_req.mode == M_IMM) n = w ? 3'd3 : 3'd2;
                        else if (i_req.mode == M_ABS) n = 3'd3;
                        else st = ST_MODE;
                    end
                    K_STA: begin
                        if (i_req.mode == M_INDX) n = 3'd2;
                        else if (i_req.mode == M_ABS || i_req.mode == M_ABSX)
                            n = 3'd4;
                        else st = ST_MODE;
                    end
                    K_STY: begin
                        if (i_req.mode == M_ABS) n = 3'd3;
                        else if (i_req.mode == M_ABSX) n = 3'd2;
                        else st = ST_MODE;
                    end
                    K_DB: n = 3'd1;
                    K_BRA, K_DW, K_PSR: n = 3'd2;
                    K_JSL: n = 3'd4;
                    default: n = 3'd3;
                endcase
            end
        end else begin
            case (e.kind)
                K_IMP: begin
                    if (i_req.mode == M_IMPL) begin
                        n = 3'd1; op = e.a;
                    end else st = ST_MODE;
                end
                K_PRI: begin
                    if (i_req.mode == M_IMM) begin
                        val = i_acc_wide ? imm_w : imm_n;
                        if (!i_acc_wide && $signed(val) > 32'sd255) st = ST_LARGE;
                        else begin
                            n = i_acc_wide ? 3'd3 : 3'd2; op = e.a + OFS_IMM;
                        end
                    end else if (i_req.mode == M_ABS || i_req.mode == M_ABSX) begin
                        val = u;
                        if (fits8) begin
                            n = 3'd2;
                            op = e.a + ((i_req.mode == M_ABS) ? OFS_DP : OFS_DPX);
                        end else if (fits16) begin
                            n = 3'd3;
                            op = e.a + ((i_req.mode == M_ABS) ? OFS_ABS : OFS_ABSX);
                        end else if (fits24) begin
                            n = 3'd4;
                            op = e.a + ((i_req.mode == M_ABS) ? OFS_LONG : OFS_LONGX);
                        end else st = ST_LARGE;
                    end else if (i_req.mode == M_SR) begin
                        val = u;
                        if (!fits8) st = ST_LARGE;
                        else begin
                            n = 3'd2; op = e.a + OFS_SR;
                        end
                    end else st = ST_MODE;
                end
                K_RMW, K_STZ, K_BIT, K_LDX: begin
                    if (i_req.mode == M_ACC && e.kind == K_RMW) begin
                        n = 3'd1; op = e.a;
                    end else if (i_req.mode == M_IMM &&
                                 (e.kind == K_BIT || e.kind == K_LDX)) begin
                        n = w ? 3'd3 : 3'd2; op = e.a; val = w ? imm_w : imm_n;
                    end else if (i_req.mode == M_ABS) begin
                        val = u;
                        if (fits8) begin
                            n = 3'd2; op = e.b;
                        end else if (fits16) begin
                            n = 3'd3; op = e.c;
                        end else st = ST_LARGE;
                    end else st = ST_MODE;
                end
                K_BRA: begin
                    if (i_req.mode != M_ABS) st = ST_MODE;
                    else if (rel >= 34'sd128 || rel < -34'sd128) st = ST_RANGE;
                    else begin
                        n = 3'd2; op = e.a; val = rel[31:0];
                    end
                end
                K_DB, K_DW: begin
                    if (i_req.mode != M_ABS) st = ST_MODE;
                    else if ((e.kind == K_DB) ? !fits8 : !fits16) st = ST_LARGE;
                    else begin
                        n = (e.kind == K_DB) ? 3'd1 : 3'd2;
                        op = u[7:0]; val = {24'd0, u[15:8]};
                    end
                end
                K_JMP: begin
                    if (i_req.mode != M_ABS) st = ST_MODE;
                    else if (u[23:16] != i_req.pc[23:16]) st = ST_BANK;
                    else begin
                        n = 3'd3; op = e.a; val = u;
                    end
                end
                K_JSL: begin
                    if (i_req.mode != M_ABS) st = ST_MODE;
                    else if (!fits24) st = ST_LARGE;
                    else begin
                        n = 3'd4; op = e.a; val = u;
                    end
                end
                K_PEA: begin
                    if (i_req.mode == M_ABS) begin
                        n = 3'd3; op = e.a; val = u;
                    end else st = ST_MODE;
                end
                K_PSR: begin
                    if (i_req.mode != M_IMM) st = ST_MODE;
                    else if ($signed(imm_n) > 32'sd255) st = ST_LARGE;
                    else begin
                        n = 3'd2; op = e.a; val = imm_n;
                    end
                end
                K_STA: begin
                    val = u;
                    if (i_req.mode == M_ABS) begin
                        if (fits8) begin
                            n = 3'd2; op = e.b;
                        end else if (fits16) begin
                            n = 3'd3; op = e.c;
                        end else if (fits24) begin
                            n = 3'd4; op = OP_STA_LONG;
                        end else st = ST_LARGE;
                    end else if (i_req.mode == M_ABSX) begin
                        if (fits16) begin
                            n = 3'd3; op = OP_STA_ABSX;
                        end else if (fits24) begin
                            n = 3'd4; op = OP_STA_LONGX;
                        end else st = ST_LARGE;
                    end else if (i_req.mode == M_INDX) begin
                        if (!fits8) st = ST_LARGE;
                        else begin
                            n = 3'd2; op = e.a;
                        end
                    end else st = ST_MODE;
                end
                K_STY: begin
                    val = u;
                    if (i_req.mode == M_ABS) begin
                        if (fits8) begin
                            n = 3'd2; op = e.b;
                        end else if (fits16) begin
                            n = 3'd3; op = e.c;
                        end else st = ST_LARGE;
                    end else if (i_req.mode == M_ABSX) begin
                        if (!fits8) st = ST_LARGE;
                        else begin
                            n = 3'd2; op = e.a;
                        end
                    end else st = ST_MODE;
                end
                default: st = ST_MODE;
            endcase
        end
        if (st != ST_OK) n = 3'd0;
    end

    // Zero every byte past the length and all bytes on worst-case sizing
    always_comb begin
        o_rsp.status     = st;
        o_rsp.byte_count = n;
        o_rsp.byte0 = (n > 3'd0 && !zero_bytes) ? op : 8'h00;
        o_rsp.byte1 = (n > 3'd1 && !zero_bytes) ? val[7:0] : 8'h00;
        o_rsp.byte2 = (n > 3'd2 && !zero_bytes) ? val[15:8] : 8'h00;
        o_rsp.byte3 = (n > 3'd3 && !zero_bytes) ? val[23:16] : 8'h00;
    end

endmodule

// ----- rtl/cpu65816_instruction_encoder_core.sv -----
// Path: a request accepted into the input register is encoded combinationally and
// written to the result register when that register is free or being read out.
// Throughput: one request per cycle; each stage advances when the next is free.
// Reset (synchronous, active low) empties both stages and clears acc_wide and index_wide.
// Top level: request and result handshakes, configuration registers, encoder.
// Depends on c816e_pkg and c816e_encode.
module cpu65816_instruction_encoder_core
    import c816e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_req       i_req,
    output logic       o_valid,
    input  logic       i_ready,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [0:0] i_cfg_data
);

    logic r_acc_wide, r_index_wide;
    logic r_in_vld, r_out_vld;
    t_req r_req;
    t_rsp r_rsp, n_rsp;
    logic adv_out, adv_in;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_wide   <= 1'b0;
            r_index_wide <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ACC_WIDE) r_acc_wide <= i_cfg_data[0];
            if (i_cfg_idx == CFG_INDEX_WIDE) r_index_wide <= i_cfg_data[0];
        end
    end

    assign adv_out = r_in_vld && (!r_out_vld || i_ready);
    assign adv_in  = !r_in_vld || adv_out;
    assign o_ready = adv_in;
    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

    c816e_encode u_encode (
        .i_req       (r_req),
        .i_acc_wide  (r_acc_wide),
        .i_index_wide(r_index_wide),
        .o_rsp       (n_rsp)
    );

    // Advance the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv_in) r_in_vld <= i_valid;
            if (adv_out) r_out_vld <= 1'b1;
            else if (i_ready) r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_valid) r_req <= i_req;
        if (adv_out) r_rsp <= n_rsp;
    end

    // Held result stays stable while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");
    // Errors carry no bytes
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != ST_OK |-> o_rsp.byte_count == 3'd0)
        else $error("error with nonzero length");
    // Length never exceeds four
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rsp.byte_count <= 3'd4)
        else $error("length above four");

endmodule

// ----- tb/testbench.sv -----
// Testbench for cpu65816_instruction_encoder_core: random and directed statements
// are checked against an in-bench encoder model. Depends on c816e_pkg.
module testbench;
    import c816e_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_req       i_req = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_rsp       o_rsp;
    logic       i_cfg_we = 1'b0;
    logic [0:0] i_cfg_idx = '0;
    logic [0:0] i_cfg_data = '0;

    t_req  pending_stmts[$];
    t_rsp  expected_enc[$];
    logic  acc_wide_m = 1'b0;
    logic  index_wide_m = 1'b0;
    bit    quiet = 1'b0;
    int    errors = 0;
    int    received = 0;
    int    cycles = 0;

    cpu65816_instruction_encoder_core dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mnemonic table: kind and base opcodes per mnemonic number
    function automatic t_entry mnemonic_row(input logic [6:0] cmd);
        t_entry e;
        e = '{K_IMP, 8'h00, 8'h00, 8'h00};
        case (cmd)
            0: e = '{K_PRI, 8'h60, 0, 0};       1: e = '{K_PRI, 8'h20, 0, 0};
            2: e = '{K_RMW, 8'h0A, 8'h06, 8'h0E};
            3: e = '{K_BRA, 8'h90, 0, 0};       4: e = '{K_BRA, 8'hB0, 0, 0};
            5: e = '{K_BRA, 8'hF0, 0, 0};
            6: e = '{K_BIT, 8'h89, 8'h24, 8'h2C};
            7: e = '{K_BRA, 8'h30, 0, 0};       8: e = '{K_BRA, 8'hD0, 0, 0};
            9: e = '{K_BRA, 8'h10, 0, 0};       10: e = '{K_BRA, 8'h80, 0, 0};
            11: e = '{K_BRA, 8'h50, 0, 0};      12: e = '{K_BRA, 8'h70, 0, 0};
            13: e = '{K_IMP, 8'h18, 0, 0};      14: e = '{K_IMP, 8'hD8, 0, 0};
            15: e = '{K_IMP, 8'h58, 0, 0};      16: e = '{K_IMP, 8'hB8, 0, 0};
            17: e = '{K_PRI, 8'hC0, 0, 0};      18: e = '{K_DB, 0, 0, 0};
            19: e = '{K_RMW, 8'h3A, 8'hC6, 8'hCE};
            20: e = '{K_IMP, 8'hCA, 0, 0};      21: e = '{K_IMP, 8'h88, 0, 0};
            22: e = '{K_DW, 0, 0, 0};           23: e = '{K_PRI, 8'h40, 0, 0};
            24: e = '{K_RMW, 8'h1A, 8'hE6, 8'hEE};
            25: e = '{K_IMP, 8'hE8, 0, 0};      26: e = '{K_IMP, 8'hC8, 0, 0};
            27: e = '{K_JMP, 8'h4C, 0, 0};      28: e = '{K_JSL, 8'h22, 0, 0};
            29: e = '{K_JMP, 8'h20, 0, 0};      30: e = '{K_PRI, 8'hA0, 0, 0};
            31: e = '{K_LDX, 8'hA2, 8'hA6, 8'hAE};
            32: e = '{K_RMW, 8'h4A, 8'h46, 8'h4E};
            33: e = '{K_IMP, 8'hEA, 0, 0};      34: e = '{K_PRI, 8'h00, 0, 0};
            35: e = '{K_PEA, 8'hF4, 0, 0};      36: e = '{K_IMP, 8'h48, 0, 0};
            37: e = '{K_IMP, 8'h8B, 0, 0};      38: e = '{K_IMP, 8'h0B, 0, 0};
            39: e = '{K_IMP, 8'h4B, 0, 0};      40: e = '{K_IMP, 8'h08, 0, 0};
            41: e = '{K_IMP, 8'hDA, 0, 0};      42: e = '{K_IMP, 8'h5A, 0, 0};
            43: e = '{K_IMP, 8'h68, 0, 0};      44: e = '{K_IMP, 8'hAB, 0, 0};
            45: e = '{K_IMP, 8'h2B, 0, 0};      46: e = '{K_IMP, 8'h28, 0, 0};
            47: e = '{K_IMP, 8'hFA, 0, 0};      48: e = '{K_IMP, 8'h7A, 0, 0};
            49: e = '{K_PSR, 8'hC2, 0, 0};      50: e = '{K_IMP, 8'h40, 0, 0};
            51: e = '{K_IMP, 8'h6B, 0, 0};      52: e = '{K_IMP, 8'h60, 0, 0};
            53: e = '{K_PRI, 8'hE0, 0, 0};      54: e = '{K_IMP, 8'h38, 0, 0};
            55: e = '{K_IMP, 8'hF8, 0, 0};      56: e = '{K_IMP, 8'h78, 0, 0};
            57: e = '{K_PSR, 8'hE2, 0, 0};
            58: e = '{K_STA, 8'h81, 8'h85, 8'h8D};
            59: e = '{K_IMP, 8'hDB, 0, 0};
            60: e = '{K_STY, 8'h94, 8'h84, 8'h8C};
            61: e = '{K_STZ, 8'h00, 8'h64, 8'h9C};
            62: e = '{K_IMP, 8'h5B, 0, 0};      63: e = '{K_IMP, 8'h1B, 0, 0};
            64: e = '{K_IMP, 8'hAA, 0, 0};      65: e = '{K_IMP, 8'hA8, 0, 0};
            66: e = '{K_IMP, 8'h7B, 0, 0};      67: e = '{K_IMP, 8'h3B, 0, 0};
            68: e = '{K_IMP, 8'hBA, 0, 0};      69: e = '{K_IMP, 8'h8A, 0, 0};
            70: e = '{K_IMP, 8'h9A, 0, 0};      71: e = '{K_IMP, 8'h9B, 0, 0};
            72: e = '{K_IMP, 8'h98, 0, 0};      73: e = '{K_IMP, 8'hBB, 0, 0};
            74: e = '{K_IMP, 8'hCB, 0, 0};      75: e = '{K_IMP, 8'hEB, 0, 0};
            76: e = '{K_IMP, 8'hFB, 0, 0};
            default: e = '{K_IMP, 8'h00, 8'h00, 8'h00};
        endcase
        return e;
    endfunction

    // Select immediate byte(s) by modifier
    function automatic longint imm_pick(input logic [31:0] u, input longint s,
                                        input logic [1:0] md, input logic wide);
        if (wide) begin
            if (md == MOD_HIGH) return longint'((u & 32'hFFFF00) >> 8);
            if (md == MOD_MID || md == MOD_LOW) return longint'(u & 32'hFFFF);
        end else begin
            if (md == MOD_HIGH) return longint'(u[23:16]);
            if (md == MOD_MID) return longint'(u[15:8]);
            if (md == MOD_LOW) return longint'(u[7:0]);
        end
        return s;
    endfunction

    function automatic t_rsp emit(input int n, input logic [7:0] op, input longint v);
        t_rsp r;
        logic [31:0] w;
        w = v[31:0];
        r = '{ST_OK, n[2:0], op, w[7:0], w[15:8], w[23:16]};
        return r;
    endfunction

    function automatic t_rsp reject(input logic [2:0] st);
        t_rsp r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    // Choose direct page, absolute or long form by size; -1 means form absent
    function automatic t_rsp size_form(input longint v, input int dp, input int ab,
                                       input int lg);
        if (dp >= 0 && v <= 255) return emit(2, dp[7:0], v);
        if (v <= 65535) return emit(3, ab[7:0], v);
        if (lg >= 0 && v <= 16777215) return emit(4, lg[7:0], v);
        return reject(ST_LARGE);
    endfunction

    function automatic t_rsp worst_size(input t_kind k, input logic [2:0] m);
        int n;
        n = 3;
        case (k)
            K_PRI: begin
                if (m == M_IMM) n = acc_wide_m ? 3 : 2;
                else if (m == M_SR) n = 2;
                else if (m == M_ABS || m == M_ABSX) n = 4;
                else return reject(ST_MODE);
            end
            K_BIT, K_LDX: begin
                if (m == M_IMM) n = ((k == K_BIT) ? acc_wide_m : index_wide_m) ? 3 : 2;
                else if (m == M_ABS) n = 3;
                else return reject(ST_MODE);
            end
            K_STA: begin
                if (m == M_INDX) n = 2;
                else if (m == M_ABS || m == M_ABSX) n = 4;
                else return reject(ST_MODE);
            end
            K_STY: begin
                if (m == M_ABS) n = 3;
                else if (m == M_ABSX) n = 2;
                else return reject(ST_MODE);
            end
            K_DB: n = 1;
            K_BRA, K_DW, K_PSR: n = 2;
            K_JSL: n = 4;
            default: n = 3;
        endcase
        return emit(n, 8'h00, 0);
    endfunction

    // Encode one statement under the current width settings
    function automatic t_rsp encode_stmt(input t_req q);
        t_entry e;
        t_rsp r;
        logic [31:0] u;
        longint s, v;
        logic w;
        e = mnemonic_row(q.cmd);
        u = q.operand;
        s = longint'(q.operand);
        r = '0;
        if (q.cmd > CMD_LAST) begin
            r = reject(ST_MODE);
        end else if (e.kind != K_IMP && !q.operand_known) begin
            if (q.final_pass) r = reject(ST_UNKNOWN);
            else begin
                r = worst_size(e.kind, q.mode);
                r.byte0 = 0; r.byte1 = 0; r.byte2 = 0; r.byte3 = 0;
            end
        end else begin
            case (e.kind)
                K_IMP: r = (q.mode == M_IMPL) ? emit(1, e.a, 0) : reject(ST_MODE);
                K_PRI: begin
                    if (q.mode == M_IMM) begin
                        v = imm_pick(u, s, q.modifier, acc_wide_m);
                        if (!acc_wide_m && v > 255) r = reject(ST_LARGE);
                        else r = emit(acc_wide_m ? 3 : 2, e.a + OFS_IMM, v);
                    end else if (q.mode == M_ABS) begin
                        r = size_form(s, e.a + OFS_DP, e.a + OFS_ABS, e.a + OFS_LONG);
                    end else if (q.mode == M_ABSX) begin
                        r = size_form(s, e.a + OFS_DPX, e.a + OFS_ABSX, e.a + OFS_LONGX);
                    end else if (q.mode == M_SR) begin
                        r = (s > 255) ? reject(ST_LARGE) : emit(2, e.a + OFS_SR, s);
                    end else r = reject(ST_MODE);
                end
                K_RMW: begin
                    if (q.mode == M_ACC) r = emit(1, e.a, 0);
                    else if (q.mode == M_ABS) r = size_form(s, e.b, e.c, -1);
                    else r = reject(ST_MODE);
                end
                K_STZ: r = (q.mode == M_ABS) ? size_form(s, e.b, e.c, -1)
                                             : reject(ST_MODE);
                K_BIT, K_LDX: begin
                    w = (e.kind == K_BIT) ? acc_wide_m : index_wide_m;
                    if (q.mode == M_IMM)
                        r = emit(w ? 3 : 2, e.a, imm_pick(u, s, q.modifier, w));
                    else if (q.mode == M_ABS) r = size_form(s, e.b, e.c, -1);
                    else r = reject(ST_MODE);
                end
                K_BRA: begin
                    v = s - longint'(q.pc) - 2;
                    if (q.mode != M_ABS) r = reject(ST_MODE);
                    else if (v >= 128 || v < -128) r = reject(ST_RANGE);
                    else r = emit(2, e.a, v);
                end
                K_DB, K_DW: begin
                    if (q.mode != M_ABS) r = reject(ST_MODE);
                    else if (s > ((e.kind == K_DB) ? 255 : 65535)) r = reject(ST_LARGE);
                    else r = emit((e.kind == K_DB) ? 1 : 2, u[7:0], longint'(u[15:8]));
                end
                K_JMP: begin
                    if (q.mode != M_ABS) r = reject(ST_MODE);
                    else if (u[23:16] != q.pc[23:16]) r = reject(ST_BANK);
                    else r = emit(3, e.a, s);
                end
                K_JSL: begin
                    if (q.mode != M_ABS) r = reject(ST_MODE);
                    else if (s > 16777215) r = reject(ST_LARGE);
                    else r = emit(4, e.a, s);
                end
                K_PEA: r = (q.mode == M_ABS) ? emit(3, e.a, s) : reject(ST_MODE);
                K_PSR: begin
                    v = imm_pick(u, s, q.modifier, 1'b0);
                    if (q.mode != M_IMM) r = reject(ST_MODE);
                    else if (v > 255) r = reject(ST_LARGE);
                    else r = emit(2, e.a, v);
                end
                K_STA: begin
                    if (q.mode == M_ABS) r = size_form(s, e.b, e.c, OP_STA_LONG);
                    else if (q.mode == M_ABSX)
                        r = size_form(s, -1, OP_STA_ABSX, OP_STA_LONGX);
                    else if (q.mode == M_INDX)
                        r = (s > 255) ? reject(ST_LARGE) : emit(2, e.a, s);
                    else r = reject(ST_MODE);
                end
                K_STY: begin
                    if (q.mode == M_ABS) r = size_form(s, e.b, e.c, -1);
                    else if (q.mode == M_ABSX)
                        r = (s > 255) ? reject(ST_LARGE) : emit(2, e.a, s);
                    else r = reject(ST_MODE);
                end
                default: r = reject(ST_MODE);
            endcase
        end
        // Drop bytes beyond the count
        if (r.status != ST_OK) r.byte_count = 0;
        if (r.byte_count < 1) r.byte0 = 0;
        if (r.byte_count < 2) r.byte1 = 0;
        if (r.byte_count < 3) r.byte2 = 0;
        if (r.byte_count < 4) r.byte3 = 0;
        return r;
    endfunction

    function automatic t_req stmt(input int cmd, input logic [2:0] m, input logic [1:0] md,
                                  input logic [31:0] op, input bit known, input bit fin,
                                  input logic [23:0] pc);
        t_req q;
        q = '{cmd[6:0], m, md, op, known, fin, pc};
        return q;
    endfunction

    // Random statement, mostly well-formed for its mnemonic
    function automatic t_req rand_stmt();
        t_req q;
        t_entry e;
        int pick;
        q.cmd = ($urandom_range(0, 29) == 0) ? 7'($urandom_range(77, 127))
                                             : 7'($urandom_range(0, 76));
        e = mnemonic_row(q.cmd);
        q.modifier = 2'($urandom);
        q.pc = 24'($urandom);
        q.operand_known = ($urandom_range(0, 9) != 0);
        q.final_pass = 1'($urandom);
        if ($urandom_range(0, 4) == 0) q.mode = 3'($urandom);
        else begin
            case (e.kind)
                K_IMP: q.mode = M_IMPL;
                K_PRI: q.mode = 3'($urandom_range(2, 5));
                K_RMW: q.mode = $urandom_range(0, 1) ? M_ACC : M_ABS;
                K_BIT, K_LDX: q.mode = $urandom_range(0, 1) ? M_IMM : M_ABS;
                K_PSR: q.mode = M_IMM;
                K_STA: q.mode = 3'($urandom_range(0, 2) == 0 ? 6 : $urandom_range(3, 4));
                K_STY: q.mode = $urandom_range(0, 1) ? M_ABSX : M_ABS;
                default: q.mode = M_ABS;
            endcase
        end
        pick = $urandom_range(0, 5);
        case (pick)
            0: q.operand = $urandom_range(0, 255);
            1: q.operand = $urandom_range(0, 65535);
            2: q.operand = $urandom_range(0, 24'hFFFFFF);
            3: q.operand = $urandom;
            default: begin
                if (e.kind == K_BRA)
                    q.operand = 32'(int'(q.pc) + 2 + $urandom_range(0, 280) - 140);
                else if (e.kind == K_JMP)
                    q.operand = {8'h00, q.pc[23:16], 16'($urandom)};
                else q.operand = $urandom_range(0, 511);
            end
        endcase
        return q;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Driver: offer pending requests, record expectations on accept
    always @(posedge i_clk) begin
        int gap;
        if (i_rst_n) begin
            if (i_valid && o_ready) expected_enc.push_back(encode_stmt(i_req));
            if (!i_valid || o_ready) begin
                if (gap > 0) begin
                    gap--;
                    i_valid <= 1'b0;
                end else if (pending_stmts.size() > 0) begin
                    i_valid <= 1'b1;
                    i_req <= pending_stmts.pop_front();
                    if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 11);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, hold off once for a long stretch, check results
    always @(posedge i_clk) begin
        int stall;
        int hold;
        bit held;
        t_rsp want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                received++;
                if (expected_enc.size() == 0) begin
                    report_mismatch("unexpected result", int'(o_rsp.status), 0);
                end else begin
                    want = expected_enc.pop_front();
                    if (o_rsp.status != want.status)
                        report_mismatch("status", int'(o_rsp.status), int'(want.status));
                    if (o_rsp.byte_count != want.byte_count)
                        report_mismatch("byte_count", int'(o_rsp.byte_count),
                                        int'(want.byte_count));
                    if (o_rsp.byte0 != want.byte0)
                        report_mismatch("byte0", int'(o_rsp.byte0), int'(want.byte0));
                    if (o_rsp.byte1 != want.byte1)
                        report_mismatch("byte1", int'(o_rsp.byte1), int'(want.byte1));
                    if (o_rsp.byte2 != want.byte2)
                        report_mismatch("byte2", int'(o_rsp.byte2), int'(want.byte2));
                    if (o_rsp.byte3 != want.byte3)
                        report_mismatch("byte3", int'(o_rsp.byte3), int'(want.byte3));
                end
                if (received == 300 && !held) begin
                    held = 1'b1;
                    hold = 80;
                end
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 11);
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Sample at the falling edge so driver and monitor updates have settled
    task automatic wait_drained();
        while (pending_stmts.size() > 0 || i_valid || expected_enc.size() > 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_widths(input logic acc, input logic idx);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_ACC_WIDE;
        i_cfg_data <= acc;
        @(posedge i_clk);
        i_cfg_idx <= CFG_INDEX_WIDE;
        i_cfg_data <= idx;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        acc_wide_m = acc;
        index_wide_m = idx;
    endtask

    initial begin
        logic [1:0] phase_cfg [5];
        phase_cfg = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b00};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: size boundaries, immediates, branches, banks, unknown operands
        pending_stmts.push_back(stmt(30, M_IMM, 0, 32'hFF, 1, 1, 0));
        pending_stmts.push_back(stmt(30, M_IMM, 0, 32'h100, 1, 1, 0));
        pending_stmts.push_back(stmt(30, M_IMM, MOD_HIGH, 32'h12345678, 1, 1, 0));
        pending_stmts.push_back(stmt(30, M_IMM, MOD_MID, 32'h12345678, 1, 1, 0));
        pending_stmts.push_back(stmt(31, M_IMM, MOD_LOW, 32'hFFFFFFFF, 1, 1, 0));
        pending_stmts.push_back(stmt(30, M_ABS, 0, 32'hFF, 1, 1, 0));
        pending_stmts.push_back(stmt(30, M_ABS, 0, 32'hFFFF, 1, 1, 0));
        pending_stmts.push_back(stmt(30, M_ABSX, 0, 32'hFFFFFF, 1, 1, 0));
        pending_stmts.push_back(stmt(30, M_ABS, 0, 32'h1000000, 1, 1, 0));
        pending_stmts.push_back(stmt(0, M_ABS, 0, 32'h80000000, 1, 1, 0));
        pending_stmts.push_back(stmt(0, M_SR, 0, 32'h7FFFFFFF, 1, 1, 0));
        pending_stmts.push_back(stmt(5, M_ABS, 0, 32'h1081, 1, 1, 24'h1000));
        pending_stmts.push_back(stmt(5, M_ABS, 0, 32'h1082, 1, 1, 24'h1000));
        pending_stmts.push_back(stmt(10, M_ABS, 0, 32'h0F82, 1, 1, 24'h1000));
        pending_stmts.push_back(stmt(10, M_ABS, 0, 32'h0F81, 1, 1, 24'h1000));
        pending_stmts.push_back(stmt(27, M_ABS, 0, 32'h123456, 1, 1, 24'h12FFFF));
        pending_stmts.push_back(stmt(29, M_ABS, 0, 32'h133456, 1, 1, 24'h12FFFF));
        pending_stmts.push_back(stmt(28, M_ABS, 0, 32'hFFFFFF, 1, 1, 24'hFFFFFF));
        pending_stmts.push_back(stmt(0, M_ABS, 0, 0, 0, 0, 0));
        pending_stmts.push_back(stmt(58, M_ABSX, 0, 0, 0, 1, 0));
        pending_stmts.push_back(stmt(33, M_IMPL, 0, 0, 0, 1, 0));
        pending_stmts.push_back(stmt(127, M_IMPL, 0, 0, 1, 1, 0));
        pending_stmts.push_back(stmt(2, 3'd7, 0, 5, 1, 1, 0));
        pending_stmts.push_back(stmt(22, M_ABS, 0, 32'hBEEF, 1, 1, 0));
        pending_stmts.push_back(stmt(60, M_ABSX, 0, 32'h100, 1, 1, 0));

        // Random phases over width settings
        foreach (phase_cfg[p]) begin
            if (p > 0) begin
                wait_drained();
                write_widths(phase_cfg[p][1], phase_cfg[p][0]);
            end
            if (p == 4) quiet = 1'b1;
            repeat (205) pending_stmts.push_back(rand_stmt());
        end
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/c816e_pkg.sv
rtl/c816e_encode.sv
rtl/cpu65816_instruction_encoder_core.sv
tb/testbench.sv
